FILE: rtl/bcps_pkg.sv
// Shared types, constants and codes of the best-candidate point sampler.
package bcps_pkg;

  localparam int GRID_SIDE_DEF  = 32;
  localparam int CELL_SLOTS_DEF = 8;
  localparam int TABLE_SIZE_DEF = 4096;
  localparam int COORD_BITS_DEF = 16;

  localparam int IO_COORD_W = 16;
  localparam int TARGET_W   = 13;
  localparam int INDEX_W    = 12;
  localparam int DIST_W     = 32;
  localparam int STATUS_W   = 2;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd4096;
  localparam logic [DIST_W-1:0]   DIST_NONE    = '1;

  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOGRID = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

  // neighbour offsets run 0..2 for -1, 0, +1
  localparam logic [1:0] NB_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FILL_RD,
    ST_COMMIT
  } bcps_state_e;

  typedef struct packed {
    logic       sweep_en;
    logic       take;
    logic       scan_en;
    logic [1:0] du;
    logic [1:0] dv;
    logic       best_upd;
    logic       fill_rd;
    logic       commit;
    logic       clear_regs;
  } bcps_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic pipe_busy;
    logic last;
    logic out_free;
  } bcps_stat_t;

endpackage

FILE: rtl/bcps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bcps_ctrl.sv
// Controller state machine: clearing pass, neighbour scan, round commit.
module bcps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  output logic                in_stall_o,
  output bcps_pkg::bcps_cmd_t cmd_o,
  input  bcps_pkg::bcps_stat_t stat_i
);

  bcps_pkg::bcps_state_e state_q, state_d;
  logic [1:0] du_q, du_d;
  logic [1:0] dv_q, dv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcps_pkg::ST_SWEEP;
      du_q    <= '0;
      dv_q    <= '0;
    end else begin
      state_q <= state_d;
      du_q    <= du_d;
      dv_q    <= dv_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    du_d       = du_q;
    dv_d       = dv_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.du   = du_q;
    cmd_o.dv   = dv_q;
    unique case (state_q)
      bcps_pkg::ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (stat_i.sweep_done) begin
          state_d = bcps_pkg::ST_IDLE;
        end
      end
      bcps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == bcps_pkg::CMD_CLEAR) begin
            cmd_o.clear_regs = 1'b1;
            state_d          = bcps_pkg::ST_SWEEP;
          end else begin
            cmd_o.take = 1'b1;
            du_d       = '0;
            dv_d       = '0;
            state_d    = bcps_pkg::ST_SCAN;
          end
        end
      end
      bcps_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (dv_q == bcps_pkg::NB_LAST) begin
          dv_d = '0;
          du_d = du_q + 2'd1;
          if (du_q == bcps_pkg::NB_LAST) begin
            state_d = bcps_pkg::ST_DRAIN;
          end
        end else begin
          dv_d = dv_q + 2'd1;
        end
      end
      bcps_pkg::ST_DRAIN: begin
        // wait for the distance pipeline to empty, then judge the candidate
        if (!stat_i.pipe_busy) begin
          cmd_o.best_upd = 1'b1;
          state_d = stat_i.last ? bcps_pkg::ST_FILL_RD : bcps_pkg::ST_IDLE;
        end
      end
      bcps_pkg::ST_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = bcps_pkg::ST_COMMIT;
      end
      bcps_pkg::ST_COMMIT: begin
        // hold until the output register can take the word
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bcps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bcps_dp.sv
// Datapath: grid memories, distance pipeline, best register and output word.
module bcps_dp #(
  parameter int GRID_SIDE  = bcps_pkg::GRID_SIDE_DEF,
  parameter int CELL_SLOTS = bcps_pkg::CELL_SLOTS_DEF,
  parameter int TABLE_SIZE = bcps_pkg::TABLE_SIZE_DEF,
  parameter int COORD_BITS = bcps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bcps_pkg::IO_COORD_W-1:0]     cand_x_i,
  input  logic [bcps_pkg::IO_COORD_W-1:0]     cand_y_i,
  input  logic                                last_candidate_i,
  input  logic                                cfg_we_i,
  input  logic [bcps_pkg::TARGET_W-1:0]       cfg_data_i,
  input  bcps_pkg::bcps_cmd_t                 cmd_i,
  output bcps_pkg::bcps_stat_t                stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bcps_pkg::INDEX_W-1:0]        sample_index_o,
  output logic [bcps_pkg::IO_COORD_W-1:0]     sample_x_o,
  output logic [bcps_pkg::IO_COORD_W-1:0]     sample_y_o,
  output logic [bcps_pkg::DIST_W-1:0]         nearest_dist2_o,
  output logic [bcps_pkg::STATUS_W-1:0]       status_o
);

  localparam int CB        = COORD_BITS;
  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW        = $clog2(NUM_CELLS);
  localparam int GW        = $clog2(GRID_SIDE);
  localparam int GSW       = $clog2(GRID_SIDE + 1);
  localparam int FW        = $clog2(CELL_SLOTS + 1);
  localparam int PTW       = 2 * CB;
  localparam int TP        = 1 << $clog2(CELL_SLOTS);
  localparam int DW        = bcps_pkg::DIST_W;

  function automatic logic [GW-1:0] cell_of(input logic [CB-1:0] c);
    logic [CB+GSW-1:0] p;
    p = (CB+GSW)'(c) * (CB+GSW)'(GRID_SIDE);
    return GW'(p >> CB);
  endfunction

  function automatic logic [GW-1:0] nb(input logic [GW-1:0] g, input logic [1:0] o);
    logic [GW-1:0] r;
    r = g;
    if (o == 2'd0) begin
      r = (g == '0) ? GW'(GRID_SIDE - 1) : g - 1'b1;
    end else if (o == bcps_pkg::NB_LAST) begin
      r = (g == GW'(GRID_SIDE - 1)) ? '0 : g + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] addr_of(input logic [GW-1:0] u, input logic [GW-1:0] v);
    return CW'(u) * CW'(GRID_SIDE) + CW'(v);
  endfunction

  // toroidal 1-D distance; past one half, fold back
  function automatic logic [CB-1:0] wrap(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB-1:0] d;
    logic [CB-1:0] z;
    d = (a > b) ? a - b : b - a;
    z = '0;
    return d[CB-1] ? z - d : d;
  endfunction

  // candidate and round state
  logic [CB-1:0]                   x_q, y_q;
  logic                            last_q;
  logic [DW-1:0]                   acc_q;
  logic [DW-1:0]                   best_dist_q;
  logic [PTW-1:0]                  best_pt_q;
  logic [bcps_pkg::TARGET_W-1:0]   count_q;
  logic [bcps_pkg::TARGET_W-1:0]   target_q;
  logic [CW-1:0]                   sweep_addr_q;

  logic [CW-1:0] scan_addr, best_addr;
  logic [FW-1:0] fill_rd;
  logic [PTW-1:0] pt_rd [CELL_SLOTS];
  logic          full, slot_free, do_write;

  assign scan_addr = addr_of(nb(cell_of(x_q), cmd_i.du), nb(cell_of(y_q), cmd_i.dv));
  assign best_addr = addr_of(cell_of(best_pt_q[PTW-1:CB]), cell_of(best_pt_q[CB-1:0]));
  assign full      = (count_q >= target_q) ||
                     (count_q >= bcps_pkg::TARGET_W'(TABLE_SIZE));
  assign slot_free = fill_rd < FW'(CELL_SLOTS);
  assign do_write  = cmd_i.commit && !full && slot_free;

  bcps_ram #(.WIDTH(FW), .DEPTH(NUM_CELLS)) u_fill (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep_en || do_write),
    .waddr_i (cmd_i.sweep_en ? sweep_addr_q : best_addr),
    .wdata_i (cmd_i.sweep_en ? FW'(0) : fill_rd + 1'b1),
    .re_i    (cmd_i.scan_en || cmd_i.fill_rd),
    .raddr_i (cmd_i.fill_rd ? best_addr : scan_addr),
    .rdata_o (fill_rd)
  );

  for (genvar s = 0; s < CELL_SLOTS; s++) begin : g_slot
    bcps_ram #(.WIDTH(PTW), .DEPTH(NUM_CELLS)) u_pts (
      .clk_i   (clk_i),
      .we_i    (do_write && (fill_rd == FW'(s))),
      .waddr_i (best_addr),
      .wdata_i (best_pt_q),
      .re_i    (cmd_i.scan_en),
      .raddr_i (scan_addr),
      .rdata_o (pt_rd[s])
    );
  end

  // distance pipeline: fold, square, sum, minimum
  logic          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [CB-1:0] dx_q [CELL_SLOTS];
  logic [CB-1:0] dy_q [CELL_SLOTS];
  logic          sv2_q [CELL_SLOTS];
  logic [PTW-1:0] sqx_q [CELL_SLOTS];
  logic [PTW-1:0] sqy_q [CELL_SLOTS];
  logic          sv3_q [CELL_SLOTS];
  logic [DW-1:0] d2_q [CELL_SLOTS];
  logic [DW-1:0] tree [1:2*TP-1];
  logic [DW-1:0] acc_d;

  for (genvar s = 0; s < CELL_SLOTS; s++) begin : g_pipe
    logic [PTW-1:0] sum;
    logic [DW-1:0]  frac;
    assign sum = sqx_q[s] + sqy_q[s];
    if (PTW >= DW) begin : g_down
      assign frac = sum[PTW-1 -: DW];
    end else begin : g_up
      assign frac = {sum, {(DW-PTW){1'b0}}};
    end
    always_ff @(posedge clk_i) begin
      dx_q[s]  <= wrap(x_q, pt_rd[s][PTW-1:CB]);
      dy_q[s]  <= wrap(y_q, pt_rd[s][CB-1:0]);
      sv2_q[s] <= FW'(s) < fill_rd;
      sqx_q[s] <= PTW'(dx_q[s]) * PTW'(dx_q[s]);
      sqy_q[s] <= PTW'(dy_q[s]) * PTW'(dy_q[s]);
      sv3_q[s] <= sv2_q[s];
      d2_q[s]  <= sv3_q[s] ? frac : bcps_pkg::DIST_NONE;
    end
  end

  for (genvar l = 0; l < TP; l++) begin : g_leaf
    if (l < CELL_SLOTS) begin : g_used
      assign tree[TP+l] = d2_q[l];
    end else begin : g_pad
      assign tree[TP+l] = bcps_pkg::DIST_NONE;
    end
  end

  for (genvar i = 1; i < TP; i++) begin : g_node
    assign tree[i] = (tree[2*i] < tree[2*i+1]) ? tree[2*i] : tree[2*i+1];
  end

  assign acc_d = (tree[1] < acc_q) ? tree[1] : acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q    <= CB'(cand_x_i);
      y_q    <= CB'(cand_y_i);
      last_q <= last_candidate_i;
      acc_q  <= bcps_pkg::DIST_NONE;
    end else if (s4_valid_q) begin
      acc_q <= acc_d;
    end
  end

  logic                          out_valid_q;
  logic [bcps_pkg::INDEX_W-1:0]  idx_q;
  logic [bcps_pkg::IO_COORD_W-1:0] ox_q, oy_q;
  logic [DW-1:0]                 od_q;
  logic [bcps_pkg::STATUS_W-1:0] ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      best_dist_q  <= '0;
      best_pt_q    <= '0;
      count_q      <= '0;
      target_q     <= bcps_pkg::TARGET_RESET;
      sweep_addr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.scan_en;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (cmd_i.sweep_en) begin
        sweep_addr_q <= (sweep_addr_q == CW'(NUM_CELLS - 1)) ? '0 : sweep_addr_q + 1'b1;
      end
      if (cmd_i.clear_regs || cmd_i.commit) begin
        best_dist_q <= '0;
        best_pt_q   <= '0;
      end else if (cmd_i.best_upd && (acc_q > best_dist_q)) begin
        best_dist_q <= acc_q;
        best_pt_q   <= {x_q, y_q};
      end
      if (cmd_i.clear_regs) begin
        count_q <= '0;
      end else if (cmd_i.commit && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (full) begin
        idx_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
        od_q  <= '0;
        ost_q <= bcps_pkg::STAT_FULL;
      end else begin
        idx_q <= count_q[bcps_pkg::INDEX_W-1:0];
        ox_q  <= bcps_pkg::IO_COORD_W'(best_pt_q[PTW-1:CB]);
        oy_q  <= bcps_pkg::IO_COORD_W'(best_pt_q[CB-1:0]);
        od_q  <= best_dist_q;
        ost_q <= slot_free ? bcps_pkg::STAT_OK : bcps_pkg::STAT_NOGRID;
      end
    end
  end

  assign stat_o.sweep_done = sweep_addr_q == CW'(NUM_CELLS - 1);
  assign stat_o.pipe_busy  = s1_valid_q || s2_valid_q || s3_valid_q || s4_valid_q;
  assign stat_o.last       = last_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign sample_index_o  = idx_q;
  assign sample_x_o      = ox_q;
  assign sample_y_o      = oy_q;
  assign nearest_dist2_o = od_q;
  assign status_o        = ost_q;

endmodule

FILE: rtl/best_candidate_point_sampler.sv
// Best-candidate point sampler: one candidate word per round step, one sample word per round.
// After reset and after every clear word the block runs a clearing pass over the cell fill
// table, one write per grid cell, and takes no input word meanwhile; target_count may be
// written at any idle time. An evaluate word makes nine reads of the cell memories, one per
// neighbouring cell with all slots of a cell read side by side, followed by a four-stage
// distance pipeline (fold, square, sum, minimum). A word that closes a round then reads the
// fill of the chosen cell and commits the point, waiting while the output register stays
// stalled. Results are held in an output register, so the next candidate is accepted while
// a sample word still waits.
module best_candidate_point_sampler #(
  parameter int GRID_SIDE  = bcps_pkg::GRID_SIDE_DEF,
  parameter int CELL_SLOTS = bcps_pkg::CELL_SLOTS_DEF,
  parameter int TABLE_SIZE = bcps_pkg::TABLE_SIZE_DEF,
  parameter int COORD_BITS = bcps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [bcps_pkg::IO_COORD_W-1:0]     cand_x_i,
  input  logic [bcps_pkg::IO_COORD_W-1:0]     cand_y_i,
  input  logic                                last_candidate_i,
  input  logic                                cfg_we_i,
  input  logic [bcps_pkg::TARGET_W-1:0]       cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bcps_pkg::INDEX_W-1:0]        sample_index_o,
  output logic [bcps_pkg::IO_COORD_W-1:0]     sample_x_o,
  output logic [bcps_pkg::IO_COORD_W-1:0]     sample_y_o,
  output logic [bcps_pkg::DIST_W-1:0]         nearest_dist2_o,
  output logic [bcps_pkg::STATUS_W-1:0]       status_o
);

  bcps_pkg::bcps_cmd_t  cmd;
  bcps_pkg::bcps_stat_t stat;

  bcps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bcps_dp #(
    .GRID_SIDE  (GRID_SIDE),
    .CELL_SLOTS (CELL_SLOTS),
    .TABLE_SIZE (TABLE_SIZE),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cand_x_i         (cand_x_i),
    .cand_y_i         (cand_y_i),
    .last_candidate_i (last_candidate_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_index_o   (sample_index_o),
    .sample_x_o       (sample_x_o),
    .sample_y_o       (sample_y_o),
    .nearest_dist2_o  (nearest_dist2_o),
    .status_o         (status_o)
  );

endmodule

FILE: rtl/bcps_chk.sv
// Port-level checker of the best-candidate point sampler, with its bind.
module bcps_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            command_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [bcps_pkg::INDEX_W-1:0]    sample_index_o,
  input logic [bcps_pkg::IO_COORD_W-1:0] sample_x_o,
  input logic [bcps_pkg::IO_COORD_W-1:0] sample_y_o,
  input logic [bcps_pkg::DIST_W-1:0]     nearest_dist2_o,
  input logic [bcps_pkg::STATUS_W-1:0]   status_o
);

  // a stalled sample word holds its valid, status, index, distance and x coordinate
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(sample_index_o) && $stable(nearest_dist2_o) && $stable(sample_x_o))
    else $error("stalled sample word changed");

  // a full round reports an empty word
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bcps_pkg::STAT_FULL) |->
      sample_index_o == '0 && sample_x_o == '0 && sample_y_o == '0 &&
      nearest_dist2_o == '0)
    else $error("full word carries data");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == bcps_pkg::STAT_OK || status_o == bcps_pkg::STAT_NOGRID ||
      status_o == bcps_pkg::STAT_FULL)
    else $error("undefined status code");

  // the input stalls once a word is taken; a clear starts the clearing pass
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in consecutive cycles");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == bcps_pkg::CMD_CLEAR) |=> ##1 in_stall_o)
    else $error("clear did not start the clearing pass");

endmodule

bind best_candidate_point_sampler bcps_chk u_bcps_chk (.*);

FILE: sim/tb_best_candidate_point_sampler.sv
// Testbench of the best-candidate point sampler: queued driver, clocked monitor, own sampler model.
`timescale 1ns / 1ps
module tb_best_candidate_point_sampler;

  localparam int GS    = 32;
  localparam int SLOTS = 8;
  localparam int TSIZE = 4096;

  typedef struct packed {
    logic        cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } cand_t;

  typedef struct packed {
    logic [bcps_pkg::INDEX_W-1:0]  idx;
    logic [15:0]                   x;
    logic [15:0]                   y;
    logic [bcps_pkg::DIST_W-1:0]   d2;
    logic [bcps_pkg::STATUS_W-1:0] st;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = bcps_pkg::CMD_EVAL;
  logic [15:0] cx = '0, cy = '0;
  logic last = 1'b0;
  logic cfg_we = 1'b0;
  logic [bcps_pkg::TARGET_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bcps_pkg::INDEX_W-1:0] o_idx;
  logic [15:0] o_x, o_y;
  logic [bcps_pkg::DIST_W-1:0] o_d2;
  logic [bcps_pkg::STATUS_W-1:0] o_st;

  always #2 clk = ~clk;

  best_candidate_point_sampler dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(cmd), .cand_x_i(cx), .cand_y_i(cy), .last_candidate_i(last),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sample_index_o(o_idx), .sample_x_o(o_x), .sample_y_o(o_y),
    .nearest_dist2_o(o_d2), .status_o(o_st)
  );

  // sampler model state
  logic [31:0] pts [GS*GS*SLOTS];
  int unsigned fill [GS*GS];
  int unsigned n_committed;
  logic [31:0] best_d2;
  logic [31:0] best_pt;
  int unsigned target_cnt;

  cand_t   pending_words[$];
  sample_t expected_samples[$];
  int      errors = 0;
  int      in_idle_pct = 0, out_stall_pct = 0;

  function automatic logic [15:0] wrap_dist(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return (d < 16'h8000) ? d : 16'(17'h10000 - d);
  endfunction

  function automatic int unsigned cell_of(logic [15:0] c);
    return (int'(c) * GS) >> 16;
  endfunction

  function automatic logic [31:0] nearest_d2(logic [15:0] x, logic [15:0] y);
    logic [31:0] best, d2;
    logic [15:0] dx, dy;
    int unsigned u, v, c;
    best = bcps_pkg::DIST_NONE;
    for (int du = 0; du < 3; du++)
      for (int dv = 0; dv < 3; dv++) begin
        u = (cell_of(x) + du + GS - 1) % GS;
        v = (cell_of(y) + dv + GS - 1) % GS;
        c = u * GS + v;
        for (int s = 0; s < fill[c]; s++) begin
          dx = wrap_dist(x, pts[c*SLOTS+s][31:16]);
          dy = wrap_dist(y, pts[c*SLOTS+s][15:0]);
          d2 = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
          if (d2 < best) best = d2;
        end
      end
    return best;
  endfunction

  task automatic predict_sample(cand_t w);
    logic [31:0] d;
    sample_t r;
    int unsigned c;
    if (w.cmd == bcps_pkg::CMD_CLEAR) begin
      foreach (fill[i]) fill[i] = 0;
      n_committed = 0; best_d2 = '0; best_pt = '0;
      return;
    end
    d = nearest_d2(w.x, w.y);
    if (d > best_d2) begin
      best_d2 = d; best_pt = {w.x, w.y};
    end
    if (!w.last) return;
    if (n_committed >= target_cnt || n_committed >= TSIZE) begin
      r = '0; r.st = bcps_pkg::STAT_FULL;
    end else begin
      c = cell_of(best_pt[31:16]) * GS + cell_of(best_pt[15:0]);
      r.st = bcps_pkg::STAT_OK;
      if (fill[c] < SLOTS) begin
        pts[c*SLOTS+fill[c]] = best_pt;
        fill[c]++;
      end else begin
        r.st = bcps_pkg::STAT_NOGRID;
      end
      r.idx = bcps_pkg::INDEX_W'(n_committed);
      r.x = best_pt[31:16]; r.y = best_pt[15:0]; r.d2 = best_d2;
      n_committed++;
    end
    best_d2 = '0; best_pt = '0;
    expected_samples = {expected_samples, r};
  endtask

  // driver: hold the word until accepted, then advance
  always @(posedge clk) begin
    cand_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w = pending_words.pop_front();
        predict_sample(w);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          cmd <= pending_words[0].cmd; cx <= pending_words[0].x;
          cy <= pending_words[0].y; last <= pending_words[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sample_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sample word idx=%0d", o_idx);
        end else begin
          e = expected_samples.pop_front();
          if (e != {o_idx, o_x, o_y, o_d2, o_st}) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch exp idx=%0d x=%h y=%h d2=%h st=%0d ",
                        "got idx=%0d x=%h y=%h d2=%h st=%0d"},
                       e.idx, e.x, e.y, e.d2, e.st, o_idx, o_x, o_y, o_d2, o_st);
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  function automatic cand_t cand(logic c, logic [15:0] x, logic [15:0] y, logic l);
    cand_t w;
    w.cmd = c; w.x = x; w.y = y; w.last = l;
    return w;
  endfunction

  task automatic queue_word(cand_t w);
    pending_words = {pending_words, w};
  endtask

  // hold off until every word is taken, every sample has come and the block is idle
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0 || in_stall)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_target(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= bcps_pkg::TARGET_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    target_cnt = v;
  endtask

  // random rounds: clustered candidates to fill cells or uniform ones, by the flag, and rare clears
  task automatic random_rounds(int n_words, bit clustered);
    int k;
    logic [15:0] bx, by;
    k = 0;
    while (k < n_words) begin
      int len;
      len = $urandom_range(1, 6);
      bx = 16'($urandom); by = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        if (clustered)
          queue_word(cand(bcps_pkg::CMD_EVAL, bx + 16'($urandom_range(0, 4095)),
                          by + 16'($urandom_range(0, 4095)), i == len - 1));
        else
          queue_word(cand(bcps_pkg::CMD_EVAL, 16'($urandom), 16'($urandom), i == len - 1));
        k++;
      end
      if ($urandom_range(199) == 0) begin
        queue_word(cand(bcps_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom)));
        k++;
      end
    end
  endtask

  initial begin
    foreach (fill[i]) fill[i] = 0;
    foreach (pts[i]) pts[i] = '0;
    n_committed = 0; best_d2 = '0; best_pt = '0; target_cnt = bcps_pkg::TARGET_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_target(4096);
    // directed: extremes, wrap corners, zero-distance round, same-cell overflow, clear
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h0000, 16'h0000, 1'b1));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'hFFFF, 16'hFFFF, 1'b1));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h0000, 16'h0000, 1'b1));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h8000, 16'h7FFF, 1'b0));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'hFFFF, 16'h0000, 1'b1));
    for (int i = 0; i < 11; i++)
      queue_word(cand(bcps_pkg::CMD_EVAL, 16'h4000 + 16'(i), 16'h4000 + 16'(2*i), 1'b1));
    queue_word(cand(bcps_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h5555, 16'hAAAA, 1'b0));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'hAAAA, 16'h5555, 1'b1));
    wait_drained();
    write_target(1);
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h1234, 16'h4321, 1'b1));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h2345, 16'h5432, 1'b1));
    wait_drained();
    write_target(0);
    queue_word(cand(bcps_pkg::CMD_CLEAR, 16'h0, 16'h0, 1'b0));
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h0001, 16'h8000, 1'b1));
    wait_drained();
    write_target(8191);
    queue_word(cand(bcps_pkg::CMD_EVAL, 16'h7FFF, 16'h8001, 1'b1));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 70; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 70; end
        default: begin in_idle_pct = 13; out_stall_pct = 13; end
      endcase
      write_target(ph == 1 ? $urandom_range(20, 60) : $urandom_range(300, 4096));
      queue_word(cand(bcps_pkg::CMD_CLEAR, 16'h0, 16'h0, 1'b0));
      random_rounds(230, 1'b1);
      random_rounds(230, ph[0]);
      wait_drained();
    end

    if (errors == 0)
      $display("tb_best_candidate_point_sampler OK");
    else
      $display("tb_best_candidate_point_sampler NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_best_candidate_point_sampler NOT OK");
    $finish;
  end

endmodule
